// ----- src/fsp_pkg.sv -----
// ============================================================================
// fsp_pkg
// Shared types, codes and helpers for the FASTA stream parser.
// ============================================================================
package fsp_pkg;

    // Input opcodes
    localparam logic OpData = 1'b0;
    localparam logic OpEnd  = 1'b1;

    // Field widths
    localparam int NameLenW   = 21;
    localparam int ContigLenW = 61;
    localparam int ContigIdxW = 32;
    localparam int ErrW       = 4;

    // Result queue geometry
    localparam int ResFifoDepth = 4;
    localparam int ResPtrW      = $clog2(ResFifoDepth);
    localparam int ResCntW      = $clog2(ResFifoDepth + 1);

    // Register map (index = paddr[4:3])
    localparam logic [1:0] RegEmitBases      = 2'd0;
    localparam logic [1:0] RegMaxNameBytes   = 2'd1;
    localparam logic [1:0] RegMaxContigLen   = 2'd2;

    // Register reset values
    localparam logic [NameLenW-1:0]   MaxNameReset   = NameLenW'(1048576);
    localparam logic [ContigLenW-1:0] MaxContigReset = '1;

    // Error codes
    localparam logic [ErrW-1:0] ErrBareCr        = 4'd0;
    localparam logic [ErrW-1:0] ErrSeqBeforeHdr  = 4'd1;
    localparam logic [ErrW-1:0] ErrHdrCtrlChar   = 4'd2;
    localparam logic [ErrW-1:0] ErrEmptyName     = 4'd3;
    localparam logic [ErrW-1:0] ErrNameTooLong   = 4'd4;
    localparam logic [ErrW-1:0] ErrBadUtf8       = 4'd5;
    localparam logic [ErrW-1:0] ErrBadBase       = 4'd6;
    localparam logic [ErrW-1:0] ErrContigTooLong = 4'd7;
    localparam logic [ErrW-1:0] ErrEmptyLine     = 4'd8;
    localparam logic [ErrW-1:0] ErrEmptyContig   = 4'd9;
    localparam logic [ErrW-1:0] ErrTooManyContig = 4'd10;
    localparam logic [ErrW-1:0] ErrNoContigs     = 4'd11;

    // Text characters
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChLf    = 8'h0a;
    localparam logic [7:0] ChCr    = 8'h0d;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChGt    = 8'h3e;
    localparam logic [7:0] ChDel   = 8'h7f;

    // UTF-8 lead byte bounds and continuation limits
    localparam logic [7:0] U8AsciiMax = 8'h7f;
    localparam logic [7:0] U8Lead2Lo  = 8'hc2;
    localparam logic [7:0] U8Lead2Hi  = 8'hdf;
    localparam logic [7:0] U8Lead3Lo  = 8'he0;
    localparam logic [7:0] U8Lead3Ed  = 8'hed;
    localparam logic [7:0] U8Lead3Hi  = 8'hef;
    localparam logic [7:0] U8Lead4Lo  = 8'hf0;
    localparam logic [7:0] U8Lead4Hi  = 8'hf4;
    localparam logic [7:0] U8ContLo   = 8'h80;
    localparam logic [7:0] U8ContHi   = 8'hbf;
    localparam logic [7:0] U8LoE0     = 8'ha0;
    localparam logic [7:0] U8HiEd     = 8'h9f;
    localparam logic [7:0] U8LoF0     = 8'h90;
    localparam logic [7:0] U8HiF4     = 8'h8f;

    // Constraint class on the next continuation byte
    localparam logic [2:0] U8ClsAny  = 3'd0;
    localparam logic [2:0] U8ClsE0   = 3'd1;
    localparam logic [2:0] U8ClsEd   = 3'd2;
    localparam logic [2:0] U8ClsF0   = 3'd3;
    localparam logic [2:0] U8ClsF4   = 3'd4;

    // Result event kinds
    typedef enum logic [2:0] {
        EV_BASE        = 3'd0,
        EV_NAME_BYTE   = 3'd1,
        EV_NAME_DONE   = 3'd2,
        EV_CONTIG_DONE = 3'd3,
        EV_ERROR       = 3'd4,
        EV_STREAM_DONE = 3'd5
    } ev_t;

    // Kind of the line being parsed
    typedef enum logic [2:0] {
        LK_START  = 3'b001,
        LK_HEADER = 3'b010,
        LK_SEQ    = 3'b100
    } line_kind_t;

    // One result item
    typedef struct packed {
        ev_t                   event_res;
        logic [7:0]            value;
        logic [ContigLenW-1:0] contig_length;
        logic [ContigIdxW-1:0] contig_index;
        logic [ErrW-1:0]       error_code;
        logic                  last;
    } res_t;

    // Results of one input item (up to two)
    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } res_pair_t;

    // Configuration registers
    typedef struct packed {
        logic                  emit_bases;
        logic [NameLenW-1:0]   max_name_bytes;
        logic [ContigLenW-1:0] max_contig_length;
    } cfg_t;

    function automatic res_t make_res(ev_t ev, logic [7:0] val,
                                      logic [ContigLenW-1:0] len,
                                      logic [ContigIdxW-1:0] idx,
                                      logic [ErrW-1:0] err);
        res_t r;
        r.event_res     = ev;
        r.value         = val;
        r.contig_length = len;
        r.contig_index  = idx;
        r.error_code    = err;
        r.last          = 1'b0;
        return r;
    endfunction

endpackage

// ----- src/fsp_res_fifo.sv -----
// ============================================================================
// fsp_res_fifo
// Small result queue: takes up to two results per cycle while room is set, gives one.
// ============================================================================
module fsp_res_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  fsp_pkg::res_pair_t push,
    output logic              room,
    output logic              m_valid,
    input  logic              m_ready,
    output fsp_pkg::res_t     head
);

    fsp_pkg::res_t                      entries_reg [fsp_pkg::ResFifoDepth];
    logic [fsp_pkg::ResPtrW-1:0]        wptr_reg, wptr_next;
    logic [fsp_pkg::ResPtrW-1:0]        rptr_reg, rptr_next;
    logic [fsp_pkg::ResCntW-1:0]        cnt_reg, cnt_next;
    logic [fsp_pkg::ResPtrW-1:0]        wptr_plus1;
    logic                               pop;

    assign m_valid    = (cnt_reg != '0);
    assign pop        = m_valid && m_ready;
    assign head       = entries_reg[rptr_reg];
    assign room       = (cnt_reg <= fsp_pkg::ResCntW'(fsp_pkg::ResFifoDepth - 2));
    assign wptr_plus1 = wptr_reg + fsp_pkg::ResPtrW'(1);

    // pointer and fill bookkeeping
    always_comb begin
        wptr_next = wptr_reg + fsp_pkg::ResPtrW'(push.count);
        rptr_next = rptr_reg + fsp_pkg::ResPtrW'(pop);
        cnt_next  = cnt_reg + fsp_pkg::ResCntW'(push.count) - fsp_pkg::ResCntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entries_reg[wptr_reg] <= push.r0;
        end
        if (push.count == 2'd2) begin
            entries_reg[wptr_plus1] <= push.r1;
        end
    end

    // writer must respect the room flag
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> room)
        else $error("result queue written without room");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= fsp_pkg::ResCntW'(fsp_pkg::ResFifoDepth))
        else $error("result queue fill count overflow");

    a_push_width: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd3)
        else $error("more than two results pushed in one transfer");

endmodule

// ----- src/fsp_parser.sv -----
// ============================================================================
// fsp_parser
// Per-byte FASTA parse state and result generation, one item per cycle.
// ============================================================================
module fsp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  fsp_pkg::cfg_t       cfg,
    input  logic                valid,
    input  logic                opcode,
    input  logic [7:0]          data_byte,
    output fsp_pkg::res_pair_t  res
);

    fsp_pkg::line_kind_t                 line_kind_reg, line_kind_next;
    logic                                pending_cr_reg, pending_cr_next;
    logic                                collecting_reg, collecting_next;
    logic                                contig_open_reg, contig_open_next;
    logic [fsp_pkg::NameLenW-1:0]        name_length_reg, name_length_next;
    logic [1:0]                          utf8_need_reg, utf8_need_next;
    logic [2:0]                          utf8_cls_reg, utf8_cls_next;
    logic                                utf8_bad_reg, utf8_bad_next;
    logic [fsp_pkg::ContigLenW-1:0]      base_count_reg, base_count_next;
    logic [fsp_pkg::ContigIdxW-1:0]      contig_count_reg, contig_count_next;
    logic                                failed_reg, failed_next;

    logic                                fail_hit;
    logic                                finish_line;
    logic [7:0]                          cont_lo, cont_hi;
    logic                                base_ok;
    logic [7:0]                          base_code;
    logic                                hdr_ctrl;

    // base letter to code
    always_comb begin
        base_ok   = 1'b1;
        base_code = 8'd0;
        case (data_byte)
            8'h41, 8'h61: base_code = 8'd0;   // A a
            8'h43, 8'h63: base_code = 8'd1;   // C c
            8'h47, 8'h67: base_code = 8'd2;   // G g
            8'h54, 8'h74: base_code = 8'd3;   // T t
            8'h4e, 8'h6e: base_code = 8'd4;   // N n
            default:      base_ok   = 1'b0;
        endcase
    end

    // control characters other than tab are illegal in a header
    assign hdr_ctrl = (data_byte < fsp_pkg::ChSpace) ? (data_byte != fsp_pkg::ChTab)
                                                      : (data_byte == fsp_pkg::ChDel);

    // allowed range of the next continuation byte
    always_comb begin
        cont_lo = fsp_pkg::U8ContLo;
        cont_hi = fsp_pkg::U8ContHi;
        case (utf8_cls_reg)
            fsp_pkg::U8ClsE0: cont_lo = fsp_pkg::U8LoE0;
            fsp_pkg::U8ClsEd: cont_hi = fsp_pkg::U8HiEd;
            fsp_pkg::U8ClsF0: cont_lo = fsp_pkg::U8LoF0;
            fsp_pkg::U8ClsF4: cont_hi = fsp_pkg::U8HiF4;
            default: ;
        endcase
    end

    // next state and results
    always_comb begin
        line_kind_next    = line_kind_reg;
        pending_cr_next   = pending_cr_reg;
        collecting_next   = collecting_reg;
        contig_open_next  = contig_open_reg;
        name_length_next  = name_length_reg;
        utf8_need_next    = utf8_need_reg;
        utf8_cls_next     = utf8_cls_reg;
        utf8_bad_next     = utf8_bad_reg;
        base_count_next   = base_count_reg;
        contig_count_next = contig_count_reg;
        fail_hit          = 1'b0;
        finish_line       = 1'b0;
        res.count         = 2'd0;
        res.r0            = '0;
        res.r1            = '0;

        if (valid && !failed_reg) begin
            if (opcode == fsp_pkg::OpEnd) begin
                // end of stream
                if (pending_cr_reg) begin
                    fail_hit = 1'b1;
                    res.r0 = fsp_pkg::make_res(fsp_pkg::EV_ERROR, '0, '0, '0,
                                               fsp_pkg::ErrBareCr);
                    res.count = 2'd1;
                end else if (line_kind_reg == fsp_pkg::LK_HEADER) begin
                    if (name_length_reg == '0) begin
                        fail_hit = 1'b1;
                        res.r0 = fsp_pkg::make_res(fsp_pkg::EV_ERROR, '0, '0, '0,
                                                   fsp_pkg::ErrEmptyName);
                        res.count = 2'd1;
                    end else if (utf8_bad_reg || utf8_need_reg != 2'd0) begin
                        fail_hit = 1'b1;
                        res.r0 = fsp_pkg::make_res(fsp_pkg::EV_ERROR, '0, '0, '0,
                                                   fsp_pkg::ErrBadUtf8);
                        res.count = 2'd1;
                    end else begin
                        // name confirmed, but its contig has no bases
                        fail_hit = 1'b1;
                        res.r0 = fsp_pkg::make_res(fsp_pkg::EV_NAME_DONE, '0, '0,
                                                   contig_count_reg, '0);
                        res.r1 = fsp_pkg::make_res(fsp_pkg::EV_ERROR, '0, '0, '0,
                                                   fsp_pkg::ErrEmptyContig);
                        res.count = 2'd2;
                    end
                end else if (contig_open_reg) begin
                    if (base_count_reg == '0) begin
                        fail_hit = 1'b1;
                        res.r0 = fsp_pkg::make_res(fsp_pkg::EV_ERROR, '0, '0, '0,
                                                   fsp_pkg::ErrEmptyContig);
                        res.count = 2'd1;
                    end else if (contig_count_reg == '1) begin
                        fail_hit = 1'b1;
                        res.r0 = fsp_pkg::make_res(fsp_pkg::EV_ERROR, '0, '0, '0,
                                                   fsp_pkg::ErrTooManyContig);
                        res.count = 2'd1;
                    end else begin
                        res.r0 = fsp_pkg::make_res(fsp_pkg::EV_CONTIG_DONE, '0,
                                                   base_count_reg, contig_count_reg, '0);
                        res.r1 = fsp_pkg::make_res(fsp_pkg::EV_STREAM_DONE, '0, '0, '0,
                                                   '0);
                        res.count = 2'd2;
                    end
                end else if (contig_count_reg == '0) begin
                    fail_hit = 1'b1;
                    res.r0 = fsp_pkg::make_res(fsp_pkg::EV_ERROR, '0, '0, '0,
                                               fsp_pkg::ErrNoContigs);
                    res.count = 2'd1;
                end else begin
                    res.r0 = fsp_pkg::make_res(fsp_pkg::EV_STREAM_DONE, '0, '0, '0, '0);
                    res.count = 2'd1;
                end

                // stream finished: back to the start state
                if (!fail_hit) begin
                    line_kind_next    = fsp_pkg::LK_START;
                    pending_cr_next   = 1'b0;
                    collecting_next   = 1'b0;
                    contig_open_next  = 1'b0;
                    name_length_next  = '0;
                    utf8_need_next    = 2'd0;
                    utf8_cls_next     = fsp_pkg::U8ClsAny;
                    utf8_bad_next     = 1'b0;
                    base_count_next   = '0;
                    contig_count_next = '0;
                end
            end else if (pending_cr_reg) begin
                // CR must be followed by LF
                if (data_byte != fsp_pkg::ChLf) begin
                    fail_hit = 1'b1;
                    res.r0 = fsp_pkg::make_res(fsp_pkg::EV_ERROR, '0, '0, '0,
                                               fsp_pkg::ErrBareCr);
                    res.count = 2'd1;
                end else begin
                    pending_cr_next = 1'b0;
                    finish_line     = 1'b1;
                end
            end else if (data_byte == fsp_pkg::ChCr) begin
                pending_cr_next = 1'b1;
            end else if (data_byte == fsp_pkg::ChLf) begin
                finish_line = 1'b1;
            end else if (line_kind_reg == fsp_pkg::LK_START &&
                         data_byte == fsp_pkg::ChGt) begin
                // new header closes any open contig
                if (contig_open_reg) begin
                    if (base_count_reg == '0) begin
                        fail_hit = 1'b1;
                        res.r0 = fsp_pkg::make_res(fsp_pkg::EV_ERROR, '0, '0, '0,
                                                   fsp_pkg::ErrEmptyContig);
                        res.count = 2'd1;
                    end else if (contig_count_reg == '1) begin
                        fail_hit = 1'b1;
                        res.r0 = fsp_pkg::make_res(fsp_pkg::EV_ERROR, '0, '0, '0,
                                                   fsp_pkg::ErrTooManyContig);
                        res.count = 2'd1;
                    end else begin
                        res.r0 = fsp_pkg::make_res(fsp_pkg::EV_CONTIG_DONE, '0,
                                                   base_count_reg, contig_count_reg, '0);
                        res.count = 2'd1;
                        contig_open_next  = 1'b0;
                        base_count_next   = '0;
                        contig_count_next = contig_count_reg + fsp_pkg::ContigIdxW'(1);
                    end
                end
                line_kind_next   = fsp_pkg::LK_HEADER;
                name_length_next = '0;
                collecting_next  = 1'b1;
                utf8_need_next   = 2'd0;
                utf8_cls_next    = fsp_pkg::U8ClsAny;
                utf8_bad_next    = 1'b0;
            end else if (line_kind_reg == fsp_pkg::LK_START && !contig_open_reg) begin
                fail_hit = 1'b1;
                res.r0 = fsp_pkg::make_res(fsp_pkg::EV_ERROR, '0, '0, '0,
                                           fsp_pkg::ErrSeqBeforeHdr);
                res.count = 2'd1;
            end else if (line_kind_reg == fsp_pkg::LK_HEADER) begin
                // header byte
                if (hdr_ctrl) begin
                    fail_hit = 1'b1;
                    res.r0 = fsp_pkg::make_res(fsp_pkg::EV_ERROR, '0, '0, '0,
                                               fsp_pkg::ErrHdrCtrlChar);
                    res.count = 2'd1;
                end else if (collecting_reg && (data_byte == fsp_pkg::ChSpace ||
                                                data_byte == fsp_pkg::ChTab)) begin
                    if (name_length_reg == '0) begin
                        fail_hit = 1'b1;
                        res.r0 = fsp_pkg::make_res(fsp_pkg::EV_ERROR, '0, '0, '0,
                                                   fsp_pkg::ErrEmptyName);
                        res.count = 2'd1;
                    end else begin
                        collecting_next = 1'b0;
                    end
                end else if (collecting_reg) begin
                    if (name_length_reg >= cfg.max_name_bytes) begin
                        fail_hit = 1'b1;
                        res.r0 = fsp_pkg::make_res(fsp_pkg::EV_ERROR, '0, '0, '0,
                                                   fsp_pkg::ErrNameTooLong);
                        res.count = 2'd1;
                    end else begin
                        name_length_next = name_length_reg + fsp_pkg::NameLenW'(1);
                        res.r0 = fsp_pkg::make_res(fsp_pkg::EV_NAME_BYTE, data_byte, '0,
                                                   contig_count_reg, '0);
                        res.count = 2'd1;
                        // incremental UTF-8 check
                        if (!utf8_bad_reg) begin
                            if (utf8_need_reg != 2'd0) begin
                                if (data_byte < cont_lo || data_byte > cont_hi) begin
                                    utf8_bad_next = 1'b1;
                                end else begin
                                    utf8_need_next = utf8_need_reg - 2'd1;
                                    utf8_cls_next  = fsp_pkg::U8ClsAny;
                                end
                            end else if (data_byte <= fsp_pkg::U8AsciiMax) begin
                                utf8_need_next = 2'd0;
                            end else if (data_byte >= fsp_pkg::U8Lead2Lo &&
                                         data_byte <= fsp_pkg::U8Lead2Hi) begin
                                utf8_need_next = 2'd1;
                                utf8_cls_next  = fsp_pkg::U8ClsAny;
                            end else if (data_byte >= fsp_pkg::U8Lead3Lo &&
                                         data_byte <= fsp_pkg::U8Lead3Hi) begin
                                utf8_need_next = 2'd2;
                                if (data_byte == fsp_pkg::U8Lead3Lo) begin
                                    utf8_cls_next = fsp_pkg::U8ClsE0;
                                end else if (data_byte == fsp_pkg::U8Lead3Ed) begin
                                    utf8_cls_next = fsp_pkg::U8ClsEd;
                                end else begin
                                    utf8_cls_next = fsp_pkg::U8ClsAny;
                                end
                            end else if (data_byte >= fsp_pkg::U8Lead4Lo &&
                                         data_byte <= fsp_pkg::U8Lead4Hi) begin
                                utf8_need_next = 2'd3;
                                if (data_byte == fsp_pkg::U8Lead4Lo) begin
                                    utf8_cls_next = fsp_pkg::U8ClsF0;
                                end else if (data_byte == fsp_pkg::U8Lead4Hi) begin
                                    utf8_cls_next = fsp_pkg::U8ClsF4;
                                end else begin
                                    utf8_cls_next = fsp_pkg::U8ClsAny;
                                end
                            end else begin
                                utf8_bad_next = 1'b1;
                            end
                        end
                    end
                end
            end else begin
                // sequence byte
                line_kind_next = fsp_pkg::LK_SEQ;
                if (!base_ok) begin
                    fail_hit = 1'b1;
                    res.r0 = fsp_pkg::make_res(fsp_pkg::EV_ERROR, '0, '0, '0,
                                               fsp_pkg::ErrBadBase);
                    res.count = 2'd1;
                end else if (base_count_reg >= cfg.max_contig_length) begin
                    fail_hit = 1'b1;
                    res.r0 = fsp_pkg::make_res(fsp_pkg::EV_ERROR, '0, '0, '0,
                                               fsp_pkg::ErrContigTooLong);
                    res.count = 2'd1;
                end else begin
                    base_count_next = base_count_reg + fsp_pkg::ContigLenW'(1);
                    if (cfg.emit_bases) begin
                        res.r0 = fsp_pkg::make_res(fsp_pkg::EV_BASE, base_code, '0,
                                                   contig_count_reg, '0);
                        res.count = 2'd1;
                    end
                end
            end

            // end of line: empty line check, header completion
            if (finish_line) begin
                line_kind_next = fsp_pkg::LK_START;
                if (line_kind_reg == fsp_pkg::LK_START) begin
                    fail_hit = 1'b1;
                    res.r0 = fsp_pkg::make_res(fsp_pkg::EV_ERROR, '0, '0, '0,
                                               fsp_pkg::ErrEmptyLine);
                    res.count = 2'd1;
                end else if (line_kind_reg == fsp_pkg::LK_HEADER) begin
                    if (name_length_reg == '0) begin
                        fail_hit = 1'b1;
                        res.r0 = fsp_pkg::make_res(fsp_pkg::EV_ERROR, '0, '0, '0,
                                                   fsp_pkg::ErrEmptyName);
                        res.count = 2'd1;
                    end else if (utf8_bad_reg || utf8_need_reg != 2'd0) begin
                        fail_hit = 1'b1;
                        res.r0 = fsp_pkg::make_res(fsp_pkg::EV_ERROR, '0, '0, '0,
                                                   fsp_pkg::ErrBadUtf8);
                        res.count = 2'd1;
                    end else begin
                        res.r0 = fsp_pkg::make_res(fsp_pkg::EV_NAME_DONE, '0, '0,
                                                   contig_count_reg, '0);
                        res.count = 2'd1;
                        contig_open_next = 1'b1;
                        base_count_next  = '0;
                    end
                end
            end
        end

        // mark the final result of this item
        if (res.count == 2'd1) begin
            res.r0.last = 1'b1;
        end else if (res.count == 2'd2) begin
            res.r1.last = 1'b1;
        end

        failed_next = failed_reg | fail_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_kind_reg    <= fsp_pkg::LK_START;
            pending_cr_reg   <= 1'b0;
            collecting_reg   <= 1'b0;
            contig_open_reg  <= 1'b0;
            name_length_reg  <= '0;
            utf8_need_reg    <= 2'd0;
            utf8_cls_reg     <= fsp_pkg::U8ClsAny;
            utf8_bad_reg     <= 1'b0;
            base_count_reg   <= '0;
            contig_count_reg <= '0;
            failed_reg       <= 1'b0;
        end else begin
            line_kind_reg    <= line_kind_next;
            pending_cr_reg   <= pending_cr_next;
            collecting_reg   <= collecting_next;
            contig_open_reg  <= contig_open_next;
            name_length_reg  <= name_length_next;
            utf8_need_reg    <= utf8_need_next;
            utf8_cls_reg     <= utf8_cls_next;
            utf8_bad_reg     <= utf8_bad_next;
            base_count_reg   <= base_count_next;
            contig_count_reg <= contig_count_next;
            failed_reg       <= failed_next;
        end
    end

    // nothing leaves the parser after the first error
    a_silent_after_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_reg |-> (res.count == 2'd0))
        else $error("result produced after error");

    a_fail_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid && fail_hit) |=> failed_reg)
        else $error("error did not latch the failed flag");

    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.count == 2'd2) |-> (!res.r0.last && res.r1.last &&
                                 res.r0.event_res != fsp_pkg::EV_ERROR))
        else $error("bad ordering of a result pair");

endmodule

// ----- src/fasta_stream_parser_top.sv -----
// ============================================================================
// fasta_stream_parser_top
// FASTA byte stream parser with strict UTF-8 name check and APB registers.
// ============================================================================
// Throughput: one input transfer per cycle while the result queue has room;
// end of stream can yield two results. An accepted transfer is first registered in
// the input register, then parsed into a four-entry result queue that feeds m_*;
// the two decouple both channels. Reset (aresetn, synchronous, active low) clears
// parse state, the error flag, the result queue, and restores all registers to their reset values.
module fasta_stream_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [7:0]  s_data_byte,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [7:0]  m_value,
    output logic [60:0] m_contig_length,
    output logic [31:0] m_contig_index,
    output logic [3:0]  m_error_code,
    output logic        m_last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    fsp_pkg::cfg_t      cfg_reg;
    logic               in_valid_reg;
    logic               in_opcode_reg;
    logic [7:0]         in_byte_reg;
    logic               parse_go;
    logic               fifo_room;
    logic               cfg_wr;
    logic [1:0]         reg_idx;
    fsp_pkg::res_pair_t res_pair;
    fsp_pkg::res_t      head;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.emit_bases        <= 1'b1;
            cfg_reg.max_name_bytes    <= fsp_pkg::MaxNameReset;
            cfg_reg.max_contig_length <= fsp_pkg::MaxContigReset;
        end else if (cfg_wr) begin
            case (reg_idx)
                fsp_pkg::RegEmitBases:    cfg_reg.emit_bases <= pwdata[0];
                fsp_pkg::RegMaxNameBytes:
                    cfg_reg.max_name_bytes <= pwdata[fsp_pkg::NameLenW-1:0];
                fsp_pkg::RegMaxContigLen:
                    cfg_reg.max_contig_length <= pwdata[fsp_pkg::ContigLenW-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            fsp_pkg::RegEmitBases:    prdata = {63'd0, cfg_reg.emit_bases};
            fsp_pkg::RegMaxNameBytes:
                prdata = {{(64 - fsp_pkg::NameLenW){1'b0}}, cfg_reg.max_name_bytes};
            fsp_pkg::RegMaxContigLen:
                prdata = {{(64 - fsp_pkg::ContigLenW){1'b0}}, cfg_reg.max_contig_length};
            default:                  prdata = 64'd0;
        endcase
    end

    // input register; drains whenever the queue can take two results
    assign parse_go = in_valid_reg && fifo_room;
    assign s_ready  = !in_valid_reg || parse_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_opcode_reg <= s_opcode;
            in_byte_reg   <= s_data_byte;
        end
    end

    fsp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .valid     (parse_go),
        .opcode    (in_opcode_reg),
        .data_byte (in_byte_reg),
        .res       (res_pair)
    );

    fsp_res_fifo u_res_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (res_pair),
        .room    (fifo_room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    // result fields
    assign m_event_res     = 3'(head.event_res);
    assign m_value         = head.value;
    assign m_contig_length = head.contig_length;
    assign m_contig_index  = head.contig_index;
    assign m_error_code    = head.error_code;
    assign m_last          = head.last;

endmodule
